// ===== rtl/bsam_pkg.sv =====
// bsam_pkg: shared types and constants for the binary search / all-matches block
// holds the item and result structs, command codes, datapath op codes and status struct
// no dependencies
package bsam_pkg;

  // default sizing of the value table
  localparam int unsigned TABLE_DEPTH_DEF = 64;
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  // fixed field widths of the item and result
  localparam int unsigned INDEX_W = 6;
  localparam int unsigned FIELD_W = 32;
  localparam int unsigned COUNT_W = 7;

  // item command codes
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  // one input item
  typedef struct packed {
    logic                      cmd;
    logic [INDEX_W-1:0]        entry_index;
    logic signed [FIELD_W-1:0] entry_value;
    logic signed [FIELD_W-1:0] search_key;
  } item_t;

  // one result item
  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] match_index;
    logic               last_result;
  } result_t;

  // operations the controller asks of the datapath
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_WRITE,
    OP_LOAD,
    OP_PROBE,
    OP_PCMP,
    OP_LREAD,
    OP_LCMP,
    OP_RINIT,
    OP_RREAD,
    OP_RCMP,
    OP_MISS,
    OP_FLUSH
  } dp_op_e;

  // datapath status back to the controller
  typedef struct packed {
    logic empty;      // search range exhausted
    logic eq;         // read entry equals key
    logic mid_zero;   // probe index is zero
    logic walk_zero;  // walk index is zero
    logic walk_end;   // walk index reached entries in use
  } dp_status_t;

endpackage

// ===== rtl/bsam_ram.sv =====
// bsam_ram: generic single-write, single-read RAM with registered read data
// parameters WIDTH and DEPTH; no package dependencies
module bsam_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bsam_ctrl.sv =====
// bsam_ctrl: controller state machine sequencing probes, left walk and right walk
// depends on bsam_pkg (op codes, status struct, command codes)
module bsam_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  cmd_i,
  input  bsam_pkg::dp_status_t  status_i,
  output bsam_pkg::dp_op_e      op_o,
  output logic                  busy_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROBE,
    ST_PCMP,
    ST_LREAD,
    ST_LCMP,
    ST_RINIT,
    ST_RREAD,
    ST_RCMP,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;
  bsam_pkg::dp_op_e op;

  // next state and op decode
  always_comb begin
    state_d = state_q;
    op      = bsam_pkg::OP_IDLE;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (cmd_i == bsam_pkg::CMD_SEARCH) begin
            op      = bsam_pkg::OP_LOAD;
            state_d = ST_PROBE;
          end else begin
            op = bsam_pkg::OP_WRITE;
          end
        end
      end
      ST_PROBE: begin
        if (status_i.empty) begin
          op      = bsam_pkg::OP_MISS;
          state_d = ST_IDLE;
        end else begin
          op      = bsam_pkg::OP_PROBE;
          state_d = ST_PCMP;
        end
      end
      ST_PCMP: begin
        op = bsam_pkg::OP_PCMP;
        if (status_i.eq) begin
          state_d = status_i.mid_zero ? ST_RINIT : ST_LREAD;
        end else begin
          state_d = ST_PROBE;
        end
      end
      ST_LREAD: begin
        op      = bsam_pkg::OP_LREAD;
        state_d = ST_LCMP;
      end
      ST_LCMP: begin
        op      = bsam_pkg::OP_LCMP;
        state_d = (status_i.eq && !status_i.walk_zero) ? ST_LREAD : ST_RINIT;
      end
      ST_RINIT: begin
        op      = bsam_pkg::OP_RINIT;
        state_d = ST_RREAD;
      end
      ST_RREAD: begin
        if (status_i.walk_end) begin
          op      = bsam_pkg::OP_FLUSH;
          state_d = ST_IDLE;
        end else begin
          op      = bsam_pkg::OP_RREAD;
          state_d = ST_RCMP;
        end
      end
      ST_RCMP: begin
        op      = bsam_pkg::OP_RCMP;
        state_d = status_i.eq ? ST_RREAD : ST_DONE;
      end
      ST_DONE: begin
        op      = bsam_pkg::OP_FLUSH;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and registered busy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != ST_IDLE);
    end
  end

  assign op_o   = op;
  assign busy_o = busy_q;

endmodule

// ===== rtl/bsam_dp.sv =====
// bsam_dp: datapath with the value table, search bounds, walk pointer and result register
// depends on bsam_pkg and bsam_ram
module bsam_dp #(
  parameter int unsigned TABLE_DEPTH = bsam_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH = bsam_pkg::VALUE_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  bsam_pkg::dp_op_e                op_i,
  input  bsam_pkg::item_t                 item_i,
  input  logic                            cfg_we_i,
  input  logic [bsam_pkg::COUNT_W-1:0]    cfg_data_i,
  output bsam_pkg::dp_status_t            status_o,
  output logic                            result_valid_o,
  output bsam_pkg::result_t               result_o
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  logic [CW-1:0]          n_q, lo_q, hi_q, walk_q;
  logic [AW-1:0]          hit_q, pend_q;
  logic [VALUE_WIDTH-1:0] key_q;
  logic                   res_valid_q;
  bsam_pkg::result_t      res_q;

  logic [CW:0]            mid_sum;
  logic [CW-1:0]          mid;
  logic [AW-1:0]          raddr;
  logic [VALUE_WIDTH-1:0] rdata;
  logic [63:0]            wext, kext;
  logic                   we, eq, gt;
  logic                   emit;
  bsam_pkg::result_t      emit_res;

  // sign-extend the fixed-width fields to 64 bits; the table keeps the low VALUE_WIDTH bits
  assign wext = 64'(item_i.entry_value);
  assign kext = 64'(item_i.search_key);

  // writes beyond the table are dropped
  assign we = (op_i == bsam_pkg::OP_WRITE) &&
              ({1'b0, item_i.entry_index} < 7'(TABLE_DEPTH));

  // probe index: floor of (lo + hi - 1) / 2 with hi exclusive
  assign mid_sum = (CW+1)'(lo_q) + (CW+1)'(hi_q) - (CW+1)'(1);
  assign mid     = mid_sum[CW:1];
  assign raddr   = (op_i == bsam_pkg::OP_PROBE) ? mid[AW-1:0] : walk_q[AW-1:0];

  bsam_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (item_i.entry_index[AW-1:0]),
    .wdata_i (wext[VALUE_WIDTH-1:0]),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // compare read entry against key as signed values
  assign eq = (rdata == key_q);
  assign gt = ($signed(rdata) > $signed(key_q));

  assign status_o.empty     = (lo_q >= hi_q);
  assign status_o.eq        = eq;
  assign status_o.mid_zero  = (mid == '0);
  assign status_o.walk_zero = (walk_q == '0);
  assign status_o.walk_end  = (walk_q >= n_q);

  // result emission: pending match goes out once it is known whether more follow
  always_comb begin
    emit     = 1'b0;
    emit_res = '0;
    case (op_i)
      bsam_pkg::OP_MISS: begin
        emit                 = 1'b1;
        emit_res.last_result = 1'b1;
      end
      bsam_pkg::OP_FLUSH: begin
        emit                 = 1'b1;
        emit_res.found       = 1'b1;
        emit_res.match_index = bsam_pkg::INDEX_W'(pend_q);
        emit_res.last_result = 1'b1;
      end
      bsam_pkg::OP_LCMP, bsam_pkg::OP_RCMP: begin
        emit                 = eq;
        emit_res.found       = 1'b1;
        emit_res.match_index = bsam_pkg::INDEX_W'(pend_q);
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // entry count register and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q         <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_data_i > 7'(TABLE_DEPTH)) begin
          n_q <= CW'(TABLE_DEPTH);
        end else begin
          n_q <= CW'(cfg_data_i);
        end
      end
      res_valid_q <= emit;
    end
  end

  // key, search bounds, walk pointer, pending match and result register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_q <= emit_res;
    end
    case (op_i)
      bsam_pkg::OP_LOAD: begin
        key_q <= kext[VALUE_WIDTH-1:0];
        lo_q  <= '0;
        hi_q  <= n_q;
      end
      bsam_pkg::OP_PCMP: begin
        if (eq) begin
          hit_q  <= mid[AW-1:0];
          pend_q <= mid[AW-1:0];
          walk_q <= mid - CW'(1);
        end else if (gt) begin
          hi_q <= mid;
        end else begin
          lo_q <= mid + CW'(1);
        end
      end
      bsam_pkg::OP_LCMP: begin
        if (eq) begin
          pend_q <= walk_q[AW-1:0];
          walk_q <= walk_q - CW'(1);
        end
      end
      bsam_pkg::OP_RINIT: begin
        walk_q <= CW'(hit_q) + CW'(1);
      end
      bsam_pkg::OP_RCMP: begin
        if (eq) begin
          pend_q <= walk_q[AW-1:0];
          walk_q <= walk_q + CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

// ===== rtl/binary_search_all_matches.sv =====
// Binary search over a table of signed values, reporting every index equal to the key.
// Write items fill the table. entry_count arrives on cfg_data_i, is saturated to TABLE_DEPTH
// and sets how many entries from index zero are searched. It is taken only while busy is low.
// A write item is done once accepted; it gives no result and leaves busy low. A search item
// keeps busy high through its binary-search probes (at most log2(TABLE_DEPTH)+1 probes), each
// a read state then a compare state, because the table RAM has a single registered read port.
// A miss then ends the search. A hit then walks left and then right from the matching index,
// a read and a compare state per further matching index, and ends by flushing the pending
// match as the final result. Results come one per strobe on result_valid_o, and last_result
// marks the end of a search. Non-final strobes fall while busy is high. The final strobe falls
// in the cycle in which busy first reads low. The receiver cannot hold results off.
// top level: depends on bsam_pkg, bsam_ctrl, bsam_dp (and bsam_ram below it)
module binary_search_all_matches #(
  parameter int unsigned TABLE_DEPTH = bsam_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH = bsam_pkg::VALUE_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  bsam_pkg::item_t              item_i,
  output logic                         result_valid_o,
  output bsam_pkg::result_t            result_o,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bsam_pkg::COUNT_W-1:0] cfg_data_i
);

  bsam_pkg::dp_op_e     op;
  bsam_pkg::dp_status_t status;
  logic                 busy_int;

  // controller
  bsam_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .cmd_i    (item_i.cmd),
    .status_i (status),
    .op_o     (op),
    .busy_o   (busy_int)
  );

  // datapath
  bsam_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (op),
    .item_i         (item_i),
    .cfg_we_i       (cfg_valid && cfg_ready),
    .cfg_data_i     (cfg_data_i),
    .status_o       (status),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  // configuration taken only while no search is running
  assign busy      = busy_int;
  assign cfg_ready = !busy_int;

endmodule

// ===== rtl/bsam_checker.sv =====
// bsam_port_props: port-level assertions for binary_search_all_matches, bound to the top level
// depends on bsam_pkg
module bsam_port_props (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input bsam_pkg::item_t   item_i,
  input logic              result_valid_o,
  input bsam_pkg::result_t result_o
);

  // a miss is always the one and only result, at index zero
  a_miss_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.found) |-> (result_o.last_result && result_o.match_index == '0))
    else $error("miss result not marked last or index not zero");

  // a search holds the block busy from the next cycle
  a_search_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.cmd == bsam_pkg::CMD_SEARCH) |=> busy)
    else $error("search accepted but block not busy");

  // a write gives no result and leaves the block free
  a_write_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.cmd == bsam_pkg::CMD_WRITE) |=> (!busy && !result_valid_o))
    else $error("write item caused a result or busy");

  // more results follow only while the search is still running
  a_more_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.last_result) |-> busy)
    else $error("non-final result while idle");

  // the final result finds the block ready for the next item
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.last_result) |-> !busy)
    else $error("final result while still busy");

endmodule

bind binary_search_all_matches bsam_port_props u_bsam_port_props (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .item_i         (item_i),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);
